// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task switcher.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int NUM_SLOTS_DEF = 16;

   localparam int CMD_W    = 2;
   localparam int TARGET_W = 4;
   localparam int STATUS_W = 3;
   localparam int SLOT_O_W = 4;
   localparam int SLOT_ST_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADMIT = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_YIELD = 2'd2,
      CMD_EXIT  = 2'd3
   } cmd_type;

   typedef enum logic [SLOT_ST_W-1:0] {
      SLOT_EMPTY      = 2'd0,
      SLOT_READY      = 2'd1,
      SLOT_RUNNING    = 2'd2,
      SLOT_TERMINATED = 2'd3
   } slot_st_type;

   typedef enum logic [STATUS_W-1:0] {
      RES_SWITCHED   = 3'd0,
      RES_NONE_READY = 3'd1,
      RES_KERNEL     = 3'd2,
      RES_ADMITTED   = 3'd3,
      RES_REFUSED    = 3'd4
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADM_CHK,
      S_CUR_CHK,
      S_SCAN,
      S_WR_OLD,
      S_WR_NEW,
      S_DONE
   } state_type;

endpackage

// ===== sv/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/round_robin_task_switcher_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_switcher_core
// Round-robin task switcher: slot status table, scan cursor, running slot.
// ----------------------------------------------------------------------------
// throughput: one item at a time; the slot scan reads one table entry per
//    cycle through the single read port of the status ram
// reset: synchronous; all slots empty, cursor 0, no running task
// ----------------------------------------------------------------------------
module round_robin_task_switcher_core #(
   parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rrts_pkg::CMD_W-1:0]    req_command,
   input  logic                          req_from_user,
   input  logic [rrts_pkg::TARGET_W-1:0] req_target_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rrts_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrts_pkg::SLOT_O_W-1:0] rsp_next_slot,
   output logic [rrts_pkg::SLOT_O_W-1:0] rsp_prev_slot,
   output logic                          rsp_prev_valid,
   output logic                          rsp_prev_saved
);

   import rrts_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int WIDE_W = (SLOT_W > TARGET_W) ? SLOT_W : TARGET_W;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   function automatic logic [SLOT_O_W-1:0] to_out(input logic [SLOT_W-1:0] s);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(s);
      return w[SLOT_O_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] to_idx(input logic [TARGET_W-1:0] t);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(t);
      return w[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(NUM_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   // control state
   state_type              state_ff, state_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic [SLOT_W-1:0]      cursor_ff, cursor_in;
   logic [SLOT_W-1:0]      run_slot_ff, run_slot_in;
   logic                   run_valid_ff, run_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   chk_valid_ff, chk_valid_in;

   // payload state
   cmd_type                cmd_ff, cmd_in;
   logic [SLOT_W-1:0]      target_ff, target_in;
   slot_st_type            cur_st_ff, cur_st_in;
   logic [SLOT_W-1:0]      scan_addr_ff, scan_addr_in;
   logic [SLOT_W-1:0]      chk_addr_ff, chk_addr_in;
   logic [SLOT_W-1:0]      hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0]      rd_addr_ff;
   result_type             res_status_ff, res_status_in;
   logic [SLOT_O_W-1:0]    res_next_ff, res_next_in;
   logic [SLOT_O_W-1:0]    res_prev_ff, res_prev_in;
   logic                   res_pv_ff, res_pv_in;
   logic                   res_saved_ff, res_saved_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_O_W-1:0]    rsp_next_ff, rsp_next_in;
   logic [SLOT_O_W-1:0]    rsp_prev_ff, rsp_prev_in;
   logic                   rsp_pv_ff, rsp_pv_in;
   logic                   rsp_saved_ff, rsp_saved_in;

   // ram port
   logic                   ram_we;
   logic [SLOT_W-1:0]      ram_waddr;
   logic [SLOT_ST_W-1:0]   ram_wdata;
   logic [SLOT_W-1:0]      ram_raddr;
   logic [SLOT_ST_W-1:0]   ram_rdata;

   // shared decode
   logic                   accept;
   logic                   target_ok;
   logic                   user_tick;
   slot_st_type            rd_st;
   logic                   scan_hit;
   logic                   scan_end;
   logic                   out_free;

   rrts_ram #(
      .WIDTH (SLOT_ST_W),
      .DEPTH (NUM_SLOTS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign target_ok = 32'(req_target_slot) < 32'(NUM_SLOTS);
   assign user_tick = (cmd_type'(req_command) != CMD_TICK) || req_from_user;
   assign rd_st     = valid_ff[rd_addr_ff] ? slot_st_type'(ram_rdata) : SLOT_EMPTY;
   assign scan_hit  = chk_valid_ff && (rd_st == SLOT_READY) &&
                      !(run_valid_ff && (chk_addr_ff == run_slot_ff));
   assign scan_end  = !chk_valid_ff && (issue_cnt_ff == CNT_W'(NUM_SLOTS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_command) == CMD_ADMIT) begin
                  state_in = target_ok ? S_ADM_CHK : S_DONE;
               end else if (!user_tick) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_CUR_CHK;
               end
            end
         end
         S_ADM_CHK: state_in = S_DONE;
         S_CUR_CHK: state_in = S_SCAN;
         S_SCAN: begin
            if (scan_hit) begin
               state_in = S_WR_OLD;
            end else if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_WR_OLD: state_in = S_WR_NEW;
         S_WR_NEW: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      valid_in      = valid_ff;
      cursor_in     = cursor_ff;
      run_slot_in   = run_slot_ff;
      run_valid_in  = run_valid_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_valid_in  = 1'b0;
      cmd_in        = cmd_ff;
      target_in     = target_ff;
      cur_st_in     = cur_st_ff;
      scan_addr_in  = scan_addr_ff;
      chk_addr_in   = chk_addr_ff;
      hit_slot_in   = hit_slot_ff;
      res_status_in = res_status_ff;
      res_next_in   = res_next_ff;
      res_prev_in   = res_prev_ff;
      res_pv_in     = res_pv_ff;
      res_saved_in  = res_saved_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_prev_in   = rsp_prev_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_saved_in  = rsp_saved_ff;
      ram_we        = 1'b0;
      ram_waddr     = run_slot_ff;
      ram_wdata     = SLOT_READY;
      ram_raddr     = run_slot_ff;

      case (state_ff)
         S_IDLE: begin
            ram_raddr = to_idx(req_target_slot);
            if (accept) begin
               cmd_in        = cmd_type'(req_command);
               target_in     = to_idx(req_target_slot);
               res_prev_in   = run_valid_ff ? to_out(run_slot_ff) : '0;
               res_pv_in     = run_valid_ff;
               res_next_in   = '0;
               res_saved_in  = 1'b0;
               res_status_in = RES_REFUSED;
               if (cmd_type'(req_command) != CMD_ADMIT) begin
                  ram_raddr     = run_slot_ff;
                  res_status_in = RES_KERNEL;
               end
            end
         end
         S_ADM_CHK: begin
            if ((rd_st == SLOT_EMPTY) || (rd_st == SLOT_TERMINATED)) begin
               ram_we        = 1'b1;
               ram_waddr     = target_ff;
               ram_wdata     = SLOT_READY;
               res_status_in = RES_ADMITTED;
            end else begin
               res_status_in = RES_REFUSED;
            end
         end
         S_CUR_CHK: begin
            cur_st_in = rd_st;
            if ((cmd_ff == CMD_EXIT) && run_valid_ff) begin
               cur_st_in = SLOT_TERMINATED;
               ram_we    = 1'b1;
               ram_waddr = run_slot_ff;
               ram_wdata = SLOT_TERMINATED;
            end
            scan_addr_in = wrap_inc(cursor_ff);
            issue_cnt_in = '0;
         end
         S_SCAN: begin
            ram_raddr = scan_addr_ff;
            if (issue_cnt_ff != CNT_W'(NUM_SLOTS)) begin
               chk_valid_in = 1'b1;
               chk_addr_in  = scan_addr_ff;
               scan_addr_in = wrap_inc(scan_addr_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (scan_hit) begin
               chk_valid_in = 1'b0;
               hit_slot_in  = chk_addr_ff;
            end else if (scan_end) begin
               res_status_in = RES_NONE_READY;
               res_next_in   = '0;
               if (cmd_ff == CMD_EXIT) begin
                  run_valid_in = 1'b0;
               end
            end
         end
         S_WR_OLD: begin
            if (run_valid_ff && (cur_st_ff == SLOT_RUNNING)) begin
               ram_we       = 1'b1;
               ram_waddr    = run_slot_ff;
               ram_wdata    = SLOT_READY;
               res_saved_in = 1'b1;
            end
         end
         S_WR_NEW: begin
            ram_we        = 1'b1;
            ram_waddr     = hit_slot_ff;
            ram_wdata     = SLOT_RUNNING;
            run_slot_in   = hit_slot_ff;
            run_valid_in  = 1'b1;
            cursor_in     = hit_slot_ff;
            res_status_in = RES_SWITCHED;
            res_next_in   = to_out(hit_slot_ff);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_next_in   = res_next_ff;
               rsp_prev_in   = res_prev_ff;
               rsp_pv_in     = res_pv_ff;
               rsp_saved_in  = res_saved_ff;
            end
         end
         default: begin
         end
      endcase

      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         cursor_ff    <= '0;
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_cnt_ff <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         cursor_ff    <= cursor_in;
         run_slot_ff  <= run_slot_in;
         run_valid_ff <= run_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      target_ff     <= target_in;
      cur_st_ff     <= cur_st_in;
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      hit_slot_ff   <= hit_slot_in;
      rd_addr_ff    <= ram_raddr;
      res_status_ff <= res_status_in;
      res_next_ff   <= res_next_in;
      res_prev_ff   <= res_prev_in;
      res_pv_ff     <= res_pv_in;
      res_saved_ff  <= res_saved_in;
      rsp_status_ff <= rsp_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_saved_ff  <= rsp_saved_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_next_slot  = rsp_next_ff;
   assign rsp_prev_slot  = rsp_prev_ff;
   assign rsp_prev_valid = rsp_pv_ff;
   assign rsp_prev_saved = rsp_saved_ff;

endmodule
